// ===== sv/ipa_pkg.sv =====
`timescale 1ns / 1ps
package ipa_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned HALF_W = 16;
    localparam int unsigned CNT_W  = $clog2(WORD_W);
    localparam int unsigned IDX_W  = 3;

    // action codes
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_AUTO   = 2'd1;
    localparam logic [1:0] ACT_MANUAL = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_P_FACTOR = 3'd0;
    localparam logic [IDX_W-1:0] REG_I_FACTOR = 3'd1;
    localparam logic [IDX_W-1:0] REG_D_FACTOR = 3'd2;
    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd3;
    localparam logic [IDX_W-1:0] REG_REVERSE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_CV_MIN   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CV_MAX   = 3'd6;

    localparam logic [HALF_W-1:0] DEF_PCT      = 16'd100;
    localparam logic [HALF_W-1:0] DEF_INTERVAL = 16'd100;
    localparam logic [HALF_W-1:0] DEF_CV_MAX   = 16'd1023;
    localparam logic [HALF_W-1:0] EQ_CV_MAX    = 16'd255;
    localparam logic [WORD_W-1:0] DIV_PCT      = 32'd100;
    localparam logic [WORD_W-1:0] DIV_TEN      = 32'd10;
    localparam logic [WORD_W-1:0] DIV_MILLI    = 32'd1000;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;

    typedef struct packed {
        logic  cv_valid;
        half_t control_value;
        half_t setpoint_out;
        word_t p_term;
        half_t i_term;
        word_t d_term;
        logic  auto_mode;
    } result_t;

    function automatic word_t sext16(input half_t v);
        sext16 = {{HALF_W{v[HALF_W-1]}}, v};
    endfunction

    // clamp a wrapped 32-bit value into the 16-bit limits
    function automatic half_t clamp16(input word_t v, input half_t lo, input half_t hi);
        if ($signed(v) > $signed(sext16(hi)))
            clamp16 = hi;
        else if ($signed(v) < $signed(sext16(lo)))
            clamp16 = lo;
        else
            clamp16 = v[HALF_W-1:0];
    endfunction

    // x * 1000 = x*1024 - x*16 - x*8
    function automatic word_t times_milli(input half_t v);
        word_t s;
        s = sext16(v);
        times_milli = (s << 10) - (s << 4) - (s << 3);
    endfunction

endpackage

// ===== sv/ipa_if.sv =====
`timescale 1ns / 1ps
interface ipa_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    ipa_pkg::word_t     now_ms;
    ipa_pkg::half_t     process_value;
    ipa_pkg::half_t     setpoint;
    ipa_pkg::half_t     manual_cv;

    modport source (output valid, action, now_ms, process_value, setpoint, manual_cv,
                    input ready);
    modport sink   (input valid, action, now_ms, process_value, setpoint, manual_cv,
                    output ready);
endinterface

interface ipa_out_if;
    logic               valid;
    logic               ready;
    logic               cv_valid;
    ipa_pkg::half_t     control_value;
    ipa_pkg::half_t     setpoint_out;
    ipa_pkg::word_t     p_term;
    ipa_pkg::half_t     i_term;
    ipa_pkg::word_t     d_term;
    logic               auto_mode;

    modport source (output valid, cv_valid, control_value, setpoint_out, p_term, i_term,
                    d_term, auto_mode, input ready);
    modport sink   (input valid, cv_valid, control_value, setpoint_out, p_term, i_term,
                    d_term, auto_mode, output ready);
endinterface

interface ipa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ipa_pkg::IDX_W-1:0]   index;
    ipa_pkg::half_t              data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/ipa_mul.sv =====
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, product wraps at 32 bits
module ipa_mul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ipa_pkg::word_t a,
    input  ipa_pkg::word_t b,
    output logic           done,
    output ipa_pkg::word_t product
);
    import ipa_pkg::*;

    word_t            acc_reg, acc_next;
    word_t            mcand_reg, mcand_next;
    word_t            mplier_reg, mplier_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = a;
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== sv/ipa_div.sv =====
`timescale 1ns / 1ps
// restoring divider, signed numerator / positive divisor, truncates toward zero;
// one quotient bit per cycle
module ipa_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ipa_pkg::word_t num,
    input  ipa_pkg::word_t den,
    output logic           done,
    output ipa_pkg::word_t quotient
);
    import ipa_pkg::*;

    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WORD_W:0]  trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[WORD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num[WORD_W-1] ? (~num + 1'b1) : num;
            den_next  = den;
            neg_next  = num[WORD_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial[WORD_W-1:0] - den_reg;
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ===== sv/integer_pid_antiwindup.sv =====
`timescale 1ns / 1ps
// Integer PID controller with anti-windup. Every request transfer yields exactly one
// result transfer. Mode changes, ignored requests and executes that are not yet due
// complete straight from idle. A due execute runs through one bit-serial multiplier and
// one bit-serial restoring divider: P needs a multiply and a divide, the integral two
// multiplies and two divides, the derivative a multiply and a divide; the I and D
// steps are skipped while their factor is zero. A new request is taken only while the
// controller is idle and the output register is empty or its result transfers in the
// same cycle. Configuration writes are accepted at any time but must only be issued
// while the controller is idle.
module integer_pid_antiwindup (
    input  logic      clk,
    input  logic      rst_n,
    ipa_in_if.sink    req,
    ipa_out_if.source rsp,
    ipa_cfg_if.sink   cfg
);
    import ipa_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_P_MUL    = 4'd1;
    localparam logic [3:0] ST_P_DIV    = 4'd2;
    localparam logic [3:0] ST_I_MUL_DT = 4'd3;
    localparam logic [3:0] ST_I_MUL_KI = 4'd4;
    localparam logic [3:0] ST_I_DIV10  = 4'd5;
    localparam logic [3:0] ST_I_DIV1K  = 4'd6;
    localparam logic [3:0] ST_D_MUL    = 4'd7;
    localparam logic [3:0] ST_D_DIV    = 4'd8;
    localparam logic [3:0] ST_SUM      = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    // configuration
    half_t p_fac_reg, i_fac_reg, d_fac_reg, intv_reg, cv_min_reg, cv_max_reg;
    logic  rev_reg;

    // controller state
    logic  auto_reg, auto_next;
    word_t last_exec_reg, last_exec_next;
    word_t prev_err_reg, prev_err_next;
    word_t prop_reg, prop_next;
    half_t integ_reg, integ_next;
    word_t scaled_reg, scaled_next;
    word_t deriv_reg, deriv_next;
    half_t last_out_reg, last_out_next;

    // working registers for one execute
    logic [3:0] state_reg, state_next;
    logic       launched_reg, launched_next;
    word_t      err_reg, err_next;
    half_t      dt_reg, dt_next;
    half_t      sp_reg, sp_next;
    word_t      tmp_reg, tmp_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;

    // arithmetic units
    logic  mul_start, mul_done, div_start, div_done;
    logic  mul_state, div_state;
    word_t mul_a, mul_b, mul_p, div_n, div_d, div_q;

    // derived values
    half_t lo, hi, pf, intv_eff, dt_calc, sp_out;
    word_t kp, ki, kd, elapsed, sum;
    logic  acc_in, slot_free, load_out, load_valid;

    ipa_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    ipa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_n),
        .den      (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // normalized limits: swapped when reversed, 0..255 when equal
    always_comb
    begin
        priority if (cv_min_reg == cv_max_reg)
        begin
            lo = '0;
            hi = EQ_CV_MAX;
        end
        else if ($signed(cv_min_reg) < $signed(cv_max_reg))
        begin
            lo = cv_min_reg;
            hi = cv_max_reg;
        end
        else
        begin
            lo = cv_max_reg;
            hi = cv_min_reg;
        end
    end

    // signed gains; reverse action flips all three
    assign pf       = (p_fac_reg != '0) ? p_fac_reg : DEF_PCT;
    assign intv_eff = (intv_reg != '0) ? intv_reg : DEF_INTERVAL;
    assign kp       = rev_reg ? (~{16'd0, pf} + 1'b1) : {16'd0, pf};
    assign ki       = rev_reg ? (~{16'd0, i_fac_reg} + 1'b1) : {16'd0, i_fac_reg};
    assign kd       = rev_reg ? {16'd0, d_fac_reg} : (~{16'd0, d_fac_reg} + 1'b1);

    assign elapsed  = req.now_ms - last_exec_reg;
    assign dt_calc  = (elapsed[WORD_W-1:HALF_W] != '0) ? '1 : elapsed[HALF_W-1:0];
    assign sum      = prop_reg + sext16(integ_reg) + deriv_reg;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && slot_free;
    assign acc_in    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // one serial operation per state; launched marks that the unit was started
    assign mul_state = (state_reg == ST_P_MUL) || (state_reg == ST_I_MUL_DT)
                    || (state_reg == ST_I_MUL_KI) || (state_reg == ST_D_MUL);
    assign div_state = (state_reg == ST_P_DIV) || (state_reg == ST_I_DIV10)
                    || (state_reg == ST_I_DIV1K) || (state_reg == ST_D_DIV);
    assign mul_start = mul_state && !launched_reg;
    assign div_start = div_state && !launched_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_P_MUL:
            begin
                mul_a = kp;
                mul_b = err_reg;
            end
            ST_I_MUL_DT:
            begin
                mul_a = {16'd0, dt_reg};
                mul_b = err_reg;
            end
            ST_I_MUL_KI:
            begin
                mul_a = tmp_reg;
                mul_b = ki;
            end
            default:
            begin
                mul_a = kd;
                mul_b = prev_err_reg - err_reg;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_P_DIV:
            begin
                div_n = tmp_reg;
                div_d = DIV_PCT;
            end
            ST_I_DIV10:
            begin
                div_n = tmp_reg;
                div_d = DIV_TEN;
            end
            ST_I_DIV1K:
            begin
                div_n = scaled_reg;
                div_d = DIV_MILLI;
            end
            default:
            begin
                div_n = tmp_reg;
                div_d = {16'd0, dt_reg};
            end
        endcase
    end

    always_comb
    begin
        auto_next      = auto_reg;
        last_exec_next = last_exec_reg;
        prev_err_next  = prev_err_reg;
        prop_next      = prop_reg;
        integ_next     = integ_reg;
        scaled_next    = scaled_reg;
        deriv_next     = deriv_reg;
        last_out_next  = last_out_reg;
        state_next     = state_reg;
        launched_next  = launched_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        sp_next        = sp_reg;
        tmp_next       = tmp_reg;
        sp_out         = req.setpoint;
        load_out       = 1'b0;
        load_valid     = 1'b0;

        if (mul_start || div_start)
            launched_next = 1'b1;
        if (mul_done || div_done)
            launched_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc_in)
                begin
                    load_out = 1'b1;
                    priority if (req.action == ACT_AUTO)
                    begin
                        if (!auto_reg)
                        begin
                            // bumpless entry: integral takes over the present CV
                            auto_next     = 1'b1;
                            prev_err_next = '0;
                            prop_next     = '0;
                            deriv_next    = '0;
                            integ_next    = clamp16(sext16(req.manual_cv), lo, hi);
                            scaled_next   = times_milli(integ_next);
                            sp_out        = req.process_value;
                        end
                    end
                    else if (req.action == ACT_MANUAL)
                    begin
                        auto_next = 1'b0;
                    end
                    else if (req.action == ACT_EXEC && auto_reg
                             && elapsed >= {16'd0, intv_eff})
                    begin
                        load_out       = 1'b0;
                        last_exec_next = req.now_ms;
                        err_next       = sext16(req.setpoint) - sext16(req.process_value);
                        dt_next        = dt_calc;
                        sp_next        = req.setpoint;
                        state_next     = ST_P_MUL;
                    end
                end
            end
            ST_P_MUL, ST_I_MUL_DT, ST_I_MUL_KI, ST_D_MUL:
            begin
                if (mul_done)
                begin
                    tmp_next = mul_p;
                    unique case (state_reg)
                        ST_P_MUL:    state_next = ST_P_DIV;
                        ST_I_MUL_DT: state_next = ST_I_MUL_KI;
                        ST_I_MUL_KI: state_next = ST_I_DIV10;
                        default:     state_next = ST_D_DIV;
                    endcase
                end
            end
            ST_P_DIV:
            begin
                if (div_done)
                begin
                    prop_next = div_q;
                    priority if (i_fac_reg != '0)
                        state_next = ST_I_MUL_DT;
                    else if (d_fac_reg != '0)
                        state_next = ST_D_MUL;
                    else
                        state_next = ST_SUM;
                end
            end
            ST_I_DIV10:
            begin
                if (div_done)
                begin
                    scaled_next = scaled_reg + div_q;
                    state_next  = ST_I_DIV1K;
                end
            end
            ST_I_DIV1K:
            begin
                if (div_done)
                begin
                    // anti-windup: clamp and reload the scaled accumulator
                    integ_next = clamp16(div_q, lo, hi);
                    if ($signed(div_q) > $signed(sext16(hi))
                        || $signed(div_q) < $signed(sext16(lo)))
                        scaled_next = times_milli(integ_next);
                    state_next = (d_fac_reg != '0) ? ST_D_MUL : ST_SUM;
                end
            end
            ST_D_DIV:
            begin
                if (div_done)
                begin
                    deriv_next    = div_q;
                    prev_err_next = err_reg;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                last_out_next = clamp16(sum, lo, hi);
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                sp_out = sp_reg;
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    load_valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_next.cv_valid      = load_valid;
        res_next.control_value = last_out_next;
        res_next.setpoint_out  = sp_out;
        res_next.p_term        = prop_next;
        res_next.i_term        = integ_next;
        res_next.d_term        = deriv_next;
        res_next.auto_mode     = auto_next;

        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_fac_reg     <= DEF_PCT;
            i_fac_reg     <= '0;
            d_fac_reg     <= '0;
            intv_reg      <= DEF_INTERVAL;
            rev_reg       <= 1'b0;
            cv_min_reg    <= '0;
            cv_max_reg    <= DEF_CV_MAX;
            auto_reg      <= 1'b0;
            last_exec_reg <= '0;
            prev_err_reg  <= '0;
            prop_reg      <= '0;
            integ_reg     <= '0;
            scaled_reg    <= '0;
            deriv_reg     <= '0;
            last_out_reg  <= '0;
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_P_FACTOR: p_fac_reg  <= cfg.data;
                    REG_I_FACTOR: i_fac_reg  <= cfg.data;
                    REG_D_FACTOR: d_fac_reg  <= cfg.data;
                    REG_INTERVAL: intv_reg   <= cfg.data;
                    REG_REVERSE:  rev_reg    <= cfg.data[0];
                    REG_CV_MIN:   cv_min_reg <= cfg.data;
                    REG_CV_MAX:   cv_max_reg <= cfg.data;
                    default:      ;
                endcase
            end
            auto_reg      <= auto_next;
            last_exec_reg <= last_exec_next;
            prev_err_reg  <= prev_err_next;
            prop_reg      <= prop_next;
            integ_reg     <= integ_next;
            scaled_reg    <= scaled_next;
            deriv_reg     <= deriv_next;
            last_out_reg  <= last_out_next;
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        dt_reg  <= dt_next;
        sp_reg  <= sp_next;
        tmp_reg <= tmp_next;
        if (load_out)
            res_reg <= res_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cv_valid      = res_reg.cv_valid;
    assign rsp.control_value = res_reg.control_value;
    assign rsp.setpoint_out  = res_reg.setpoint_out;
    assign rsp.p_term        = res_reg.p_term;
    assign rsp.i_term        = res_reg.i_term;
    assign rsp.d_term        = res_reg.d_term;
    assign rsp.auto_mode     = res_reg.auto_mode;

    // the two serial units never finish together
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_done && div_done))
        else $error("multiplier and divider finished in the same cycle");

    // no operation is in flight while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !launched_reg)
        else $error("serial operation pending in idle");

    // a finished execute always hands over a result flagged as computed
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && slot_free) |=> (out_valid_reg && res_reg.cv_valid))
        else $error("execute result lost");

    // a unit only finishes in a state that started it
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        (!mul_done || mul_state) && (!div_done || div_state))
        else $error("unit finished outside its state");

endmodule

// ===== verif/ipa_checker.sv =====
`timescale 1ns / 1ps
// Watches request, result and config transfers; predicts and compares.
module ipa_checker (
    input  logic  clk,
    input  logic  rst_n,
    ipa_in_if     req,
    ipa_out_if    rsp,
    ipa_cfg_if    cfg,
    output int    errors,
    output int    results_seen
);
    import ipa_pkg::*;

    // controller settings
    bit [15:0] p_pct, i_gain, d_gain, interval;
    bit        reverse;
    int        lim_a, lim_b;

    // controller state
    bit        in_auto;
    bit [31:0] last_exec;
    int        prev_err, prop, integ, integ_milli, deriv, cv_last;

    result_t   pending_cv[$];

    function automatic int clip(int v, int lo, int hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function void pid_step(input logic [1:0] act, input bit [31:0] now,
                           input half_t pv_w, input half_t sp_w, input half_t mcv_w,
                           output result_t r);
        int lo, hi, pv, sp, mcv, sp_out, err, kp, ki, kd, dt, inc, q, de;
        bit [31:0] due, elapsed;
        bit ok;
        pv = $signed(pv_w);
        sp = $signed(sp_w);
        mcv = $signed(mcv_w);
        sp_out = sp;
        ok = 0;
        if (lim_a == lim_b) begin lo = 0; hi = 255; end
        else if (lim_a < lim_b) begin lo = lim_a; hi = lim_b; end
        else begin lo = lim_b; hi = lim_a; end

        if (act == ACT_AUTO) begin
            if (!in_auto) begin
                in_auto = 1;
                prev_err = 0;
                sp_out = pv;
                prop = 0;
                deriv = 0;
                integ = clip(mcv, lo, hi);
                integ_milli = integ * 1000;
            end
        end else if (act == ACT_MANUAL) begin
            in_auto = 0;
        end else if (act == ACT_EXEC && in_auto) begin
            due = (interval != 0) ? interval : 100;
            elapsed = now - last_exec;
            if (elapsed >= due) begin
                dt = (elapsed > 65535) ? 65535 : int'(elapsed);
                err = sp - pv;
                kp = (p_pct != 0) ? int'(p_pct) : 100;
                ki = int'(i_gain);
                kd = -int'(d_gain);
                if (reverse) begin kp = -kp; ki = -ki; kd = -kd; end
                last_exec = now;
                prop = (kp * err) / 100;
                if (ki != 0) begin
                    inc = ((dt * err) * ki) / 10;
                    integ_milli = integ_milli + inc;
                    q = integ_milli / 1000;
                    // anti-windup: reload scaled integral at the limit
                    if (q > hi) begin integ = hi; integ_milli = hi * 1000; end
                    else if (q < lo) begin integ = lo; integ_milli = lo * 1000; end
                    else integ = q;
                end
                if (kd != 0) begin
                    de = prev_err - err;
                    prev_err = err;
                    deriv = (kd * de) / dt;
                end
                cv_last = clip(prop + integ + deriv, lo, hi);
                ok = 1;
            end
        end
        r.cv_valid      = ok;
        r.control_value = cv_last[15:0];
        r.setpoint_out  = sp_out[15:0];
        r.p_term        = prop;
        r.i_term        = integ[15:0];
        r.d_term        = deriv;
        r.auto_mode     = in_auto;
    endfunction

    task automatic report(input string fld, input logic [31:0] exp_v, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t r, e;
        if (!rst_n) begin
            p_pct = DEF_PCT; i_gain = 0; d_gain = 0; interval = DEF_INTERVAL;
            reverse = 0; lim_a = 0; lim_b = 1023;
            in_auto = 0; last_exec = 0; prev_err = 0; prop = 0; integ = 0;
            integ_milli = 0; deriv = 0; cv_last = 0;
            pending_cv.delete();
            errors = 0;
            results_seen = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_P_FACTOR: p_pct    = cfg.data;
                    REG_I_FACTOR: i_gain   = cfg.data;
                    REG_D_FACTOR: d_gain   = cfg.data;
                    REG_INTERVAL: interval = cfg.data;
                    REG_REVERSE:  reverse  = cfg.data[0];
                    REG_CV_MIN:   lim_a    = $signed(cfg.data);
                    REG_CV_MAX:   lim_b    = $signed(cfg.data);
                    default: ;
                endcase
            end
            // result first: it can only belong to an earlier request
            if (rsp.valid && rsp.ready) begin
                results_seen++;
                if (pending_cv.size() == 0) begin
                    $display("%0t: result with nothing expected, got cv %0h", $time,
                             rsp.control_value);
                    errors++;
                end else begin
                    e = pending_cv.pop_front();
                    if (rsp.cv_valid !== e.cv_valid)
                        report("cv_valid", e.cv_valid, rsp.cv_valid);
                    if (rsp.control_value !== e.control_value)
                        report("control_value", e.control_value, rsp.control_value);
                    if (rsp.setpoint_out !== e.setpoint_out)
                        report("setpoint_out", e.setpoint_out, rsp.setpoint_out);
                    if (rsp.p_term !== e.p_term) report("p_term", e.p_term, rsp.p_term);
                    if (rsp.i_term !== e.i_term) report("i_term", e.i_term, rsp.i_term);
                    if (rsp.d_term !== e.d_term) report("d_term", e.d_term, rsp.d_term);
                    if (rsp.auto_mode !== e.auto_mode)
                        report("auto_mode", e.auto_mode, rsp.auto_mode);
                end
            end
            if (req.valid && req.ready) begin
                pid_step(req.action, req.now_ms, req.process_value, req.setpoint,
                         req.manual_cv, r);
                pending_cv.push_back(r);
            end
        end
    end

endmodule

// ===== verif/integer_pid_antiwindup_tb.sv =====
`timescale 1ns / 1ps
// Stimulus and verdict; all checking lives in ipa_checker.
module integer_pid_antiwindup_tb;
    import ipa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_START  = 6000;   // receiver goes quiet here
    localparam int HOLD_LEN    = 3000;

    logic clk = 0;
    logic rst_n = 0;

    ipa_in_if  req_if();
    ipa_out_if rsp_if();
    ipa_cfg_if cfg_if();

    int errors, results_seen;
    int sent = 0;
    int cycles = 0;
    int burst_left = 0;
    bit [31:0] t_ms;

    integer_pid_antiwindup dut (.clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if),
                                .cfg(cfg_if));

    ipa_checker chk (.clk(clk), .rst_n(rst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if),
                     .errors(errors), .results_seen(results_seen));

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("integer_pid_antiwindup verification failed");
            $finish;
        end
    end

    // Receiver: the stall pattern is redrawn whenever its random run ends, plus one long
    // hold-off so the output register fills and the request side backs up.
    initial
    begin
        int mode, left, n;
        rsp_if.ready = 0;
        mode = 0;
        left = 0;
        n = 0;
        forever
        begin
            @(posedge clk);
            n++;
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 300);
            end
            left--;
            if (n >= HOLD_START && n < HOLD_START + HOLD_LEN)
                rsp_if.ready <= 0;
            else
                case (mode)
                    0: rsp_if.ready <= 1;
                    1: rsp_if.ready <= $urandom_range(0, 1);
                    2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // mostly random, with a fair share of the extremes
    function automatic half_t pick16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return half_t'($urandom_range(0, 400)) - 16'd200;
            default: return half_t'($urandom);
        endcase
    endfunction

    // one request transfer; random bursts and gaps on the request side
    task automatic send(input logic [1:0] act, input bit [31:0] now, input half_t pv,
                        input half_t sp, input half_t mcv);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 0;
                repeat ($urandom_range(1, 25)) @(posedge clk);
            end
        end
        burst_left--;
        req_if.valid         <= 1;
        req_if.action        <= act;
        req_if.now_ms        <= now;
        req_if.process_value <= pv;
        req_if.setpoint      <= sp;
        req_if.manual_cv     <= mcv;
        do @(posedge clk); while (!req_if.ready);
        sent++;
    endtask

    task automatic settle();
        req_if.valid <= 0;
        @(posedge clk);
        while (results_seen != sent) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input half_t val);
        cfg_if.valid <= 1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_gains(input half_t p, input half_t i, input half_t d,
                             input half_t intv, input bit rev, input half_t mn,
                             input half_t mx);
        settle();
        write_reg(REG_P_FACTOR, p);
        write_reg(REG_I_FACTOR, i);
        write_reg(REG_D_FACTOR, d);
        write_reg(REG_INTERVAL, intv);
        write_reg(REG_REVERSE, {15'd0, rev});
        write_reg(REG_CV_MIN, mn);
        write_reg(REG_CV_MAX, mx);
    endtask

    // random stream: mostly executes in auto with time stepping near the interval
    task automatic run_phase(input int count, input int intv);
        int k, sel;
        half_t pv;
        logic [1:0] act;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 72) act = ACT_EXEC;
            else if (sel < 84) act = ACT_AUTO;
            else if (sel < 94) act = ACT_MANUAL;
            else act = 2'd3;   // undefined action, ignored
            sel = $urandom_range(0, 19);
            if (sel < 14) t_ms += intv + $urandom_range(0, 60);
            else if (sel < 17) t_ms += $urandom_range(0, intv);
            else if (sel < 19) t_ms += $urandom_range(0, 65535);
            else t_ms += $urandom;
            pv = pick16();
            send(act, t_ms, pv,
                 ($urandom_range(0, 2) == 0) ? pv + half_t'($urandom_range(0, 20)) : pick16(),
                 pick16());
        end
    endtask

    initial
    begin
        int ph, iv;
        req_if.valid = 0;
        req_if.action = ACT_EXEC;
        req_if.now_ms = 0;
        req_if.process_value = 0;
        req_if.setpoint = 0;
        req_if.manual_cv = 0;
        cfg_if.valid = 0;
        cfg_if.index = REG_P_FACTOR;
        cfg_if.data = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, reset settings
        send(ACT_EXEC, 200, 16'd10, 16'd20, 0);              // manual: no compute
        send(ACT_AUTO, 0, 16'd5, 16'd9, 16'h8000);           // integral clamps low
        send(ACT_AUTO, 0, 16'd6, 16'd9, 16'd7);              // already auto
        send(ACT_EXEC, 50, 16'd10, 16'd20, 0);               // not yet due
        send(ACT_EXEC, 100, 16'd10, 16'd20, 0);
        send(2'd3, 300, 16'd1, 16'd2, 0);
        send(ACT_EXEC, 300, 16'h8000, 16'h7fff, 0);
        send(ACT_EXEC, 500, 16'h7fff, 16'h8000, 0);
        send(ACT_MANUAL, 0, 0, 0, 0);
        send(ACT_MANUAL, 0, 0, 0, 0);
        send(ACT_AUTO, 0, 16'd3, 16'd0, 16'h7fff);           // integral clamps high

        // zero gains mean defaults; I and D on; wrap of the ms counter
        set_gains(0, 16'd50, 16'd40, 0, 0, 16'hff00, 16'd500);
        send(ACT_EXEC, 32'hffff_ff00, 16'd0, 16'd100, 0);
        send(ACT_EXEC, 32'h0000_0010, 16'd20, 16'd100, 0);   // elapsed across the wrap
        send(ACT_EXEC, 32'h8000_0000, 16'd50, 16'd100, 0);   // dt saturates
        send(ACT_EXEC, 32'h8000_0001, 16'd60, 16'd100, 0);   // not due

        // largest gains, reverse action, swapped limits
        set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 16'h7fff, 16'h8000);
        send(ACT_MANUAL, 0, 0, 0, 0);
        send(ACT_AUTO, 0, 16'd0, 16'd0, 16'd1234);
        send(ACT_EXEC, 32'h0001_0000, 16'h8000, 16'h7fff, 0);
        send(ACT_EXEC, 32'h0002_0000, 16'h7fff, 16'h8000, 0);

        // equal limits: 0..255
        set_gains(16'd1, 16'd1, 16'd1, 16'd1, 0, 16'd77, 16'd77);
        send(ACT_MANUAL, 0, 0, 0, 0);
        send(ACT_AUTO, 0, 16'd0, 16'd0, 16'd300);
        send(ACT_EXEC, 32'h0002_0001, 16'd0, 16'd200, 0);
        send(ACT_EXEC, 32'h0002_0003, 16'd0, 16'h8000, 0);

        // random phases with random settings, some extreme
        for (ph = 0; ph < 7; ph++)
        begin
            iv = (ph == 6) ? 65535 : $urandom_range(0, 300);
            set_gains(($urandom_range(0, 3) == 0) ? 16'hffff : half_t'($urandom_range(0, 400)),
                      ($urandom_range(0, 3) == 0) ? 16'd0 : half_t'($urandom),
                      ($urandom_range(0, 3) == 0) ? 16'd0 : half_t'($urandom),
                      half_t'(iv), $urandom_range(0, 1), pick16(), pick16());
            if (iv == 0) iv = 100;
            t_ms = $urandom;
            send(ACT_AUTO, t_ms, pick16(), pick16(), pick16());
            run_phase(95, iv);
        end

        settle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("integer_pid_antiwindup verification clean");
        else
            $display("integer_pid_antiwindup verification failed");
        $finish;
    end

endmodule
